// File: hw/rtl/twsm_pkg.sv
`timescale 1ns / 1ps
package twsm_pkg;
  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_ILLEGAL   = 4'd1;
  localparam logic [3:0] ST_START_ND  = 4'd2;
  localparam logic [3:0] ST_START_HR  = 4'd3;
  localparam logic [3:0] ST_NO_DASH   = 4'd6;
  localparam logic [3:0] ST_STOP_ND   = 4'd7;
  localparam logic [3:0] ST_STOP_HR   = 4'd8;
  localparam logic [3:0] ST_DANGLING  = 4'd11;
  localparam logic [3:0] ST_FULL      = 4'd12;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_END   = 8'h00;

  localparam int unsigned SecW = 17;

  // window table depth; window_count is 5 bits wide
  localparam int unsigned MaxWindows = 16;

  // parser state carried between characters
  typedef struct packed {
    logic [3:0]      phase;
    logic [6:0]      acc;
    logic            neg;
    logic [SecW-1:0] start_sec;
    logic [SecW-1:0] stop_sec;
    logic            illegal;
    logic [3:0]      err;
  } parse_t;
endpackage

// File: hw/rtl/time_window_schedule_matcher.sv
`timescale 1ns / 1ps
// Channel | Direction | Fields
// in      | input     | op, spec_char, last_char, query_hour/minute/second
// out     | output    | status, matched, window_count
// The last spec character writes the window memory if it parses cleanly and
// the table is not full. A match query reads the window memory one entry per
// cycle through a read register and a compare stage. Clear zeroes the count.
// rst_ni clears the count and parser; window contents need no clearing.
// The input stalls while a query runs or a result waits in the output register.
module time_window_schedule_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] spec_char_i,
  input  logic       last_char_i,
  input  logic [4:0] query_hour_i,
  input  logic [5:0] query_minute_i,
  input  logic [5:0] query_second_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] status_o,
  output logic       matched_o,
  output logic [4:0] window_count_o
);
  import twsm_pkg::*;

  localparam int unsigned IdxW = (MaxWindows > 1) ? $clog2(MaxWindows) : 1;
  localparam int unsigned CntW = $clog2(MaxWindows + 1);

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_SCAN = 2'b10} state_e;

  logic [2*SecW-1:0] win_mem [MaxWindows];
  logic [2*SecW-1:0] rd_q;

  state_e state_q, state_d;
  parse_t par_q, par_nxt;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] idx_q;
  logic rd_vld_q;
  logic [SecW-1:0] tgt_q;
  logic hit_q;
  logic out_vld_q;
  logic [3:0] st_q;
  logic mt_q;

  logic acc;
  op_e op;
  assign op = op_e'(op_i);
  assign in_stall_o = out_vld_q || (state_q != S_IDLE);
  assign acc = in_valid_i && !in_stall_o;

  twsm_parser u_parser (.cur_i(par_q), .char_i(spec_char_i), .last_i(last_char_i),
                        .nxt_o(par_nxt));

  logic store;
  logic [3:0] fin_st;
  always_comb begin
    store = 1'b0;
    if (par_nxt.illegal) fin_st = ST_ILLEGAL;
    else if (par_nxt.err != ST_OK) fin_st = par_nxt.err;
    else if (cnt_q >= CntW'(MaxWindows)) fin_st = ST_FULL;
    else begin
      fin_st = ST_OK;
      store = 1'b1;
    end
  end

  logic wr_en;
  assign wr_en = acc && op == OP_CHAR && last_char_i && store;

  always_ff @(posedge clk_i) begin
    if (wr_en) win_mem[cnt_q[IdxW-1:0]] <= {par_nxt.start_sec, par_nxt.stop_sec};
    rd_q <= win_mem[idx_q[IdxW-1:0]];
  end

  logic [SecW-1:0] s, e;
  logic hit;
  assign s = rd_q[2*SecW-1:SecW];
  assign e = rd_q[SecW-1:0];
  always_comb begin
    if (s == e) hit = 1'b0;
    else if (e > s) hit = tgt_q >= s && tgt_q < e;
    else hit = tgt_q >= s || tgt_q < e;
  end

  logic [SecW-1:0] tgt;
  assign tgt = SecW'(query_hour_i) * SecW'(3600) + SecW'(query_minute_i) * SecW'(60)
             + SecW'(query_second_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (acc && op == OP_QUERY && cnt_q != '0) state_d = S_SCAN;
      S_SCAN: if (!rd_vld_q && idx_q == cnt_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      par_q     <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      rd_vld_q <= (state_q == S_SCAN) && (idx_q != cnt_q);
      if (acc) begin
        unique case (op)
          OP_CHAR: begin
            if (last_char_i) begin
              par_q <= '0;
              out_vld_q <= 1'b1;
              if (store) cnt_q <= cnt_q + CntW'(1);
            end else par_q <= par_nxt;
          end
          OP_QUERY: begin
            hit_q <= 1'b0;
            idx_q <= '0;
            if (cnt_q == '0) out_vld_q <= 1'b1;
          end
          OP_CLEAR: begin
            cnt_q <= '0;
            out_vld_q <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state_q == S_SCAN) begin
        if (idx_q != cnt_q) idx_q <= idx_q + CntW'(1);
        if (rd_vld_q && hit) hit_q <= 1'b1;
        if (state_d == S_IDLE) out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      tgt_q <= tgt;
      st_q  <= (op == OP_CHAR) ? fin_st : ST_OK;
      mt_q  <= 1'b0;
    end
    if (state_q == S_SCAN && state_d == S_IDLE) mt_q <= hit_q;
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = st_q;
  assign matched_o      = mt_q;
  assign window_count_o = 5'(cnt_q);
endmodule

// File: hw/rtl/twsm_parser.sv
`timescale 1ns / 1ps
// Combinational next state of the spec parser for one character.
module twsm_parser (
  input  twsm_pkg::parse_t cur_i,
  input  logic [7:0]       char_i,
  input  logic             last_i,
  output twsm_pkg::parse_t nxt_o
);
  import twsm_pkg::*;

  function automatic logic is_dig(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic parse_t set_err(parse_t p, logic [3:0] e);
    parse_t r;
    r = p;
    if (r.err == ST_OK) r.err = e;
    return r;
  endfunction

  function automatic parse_t close_field(parse_t p, logic [7:0] term);
    parse_t r;
    logic part;
    logic [2:0] sub;
    logic [1:0] f;
    logic [6:0] lim;
    logic [SecW-1:0] add;
    r = p;
    part = p.phase[3];
    sub = p.phase[2:0];
    f = (sub <= 3'd1) ? 2'd0 : ((sub <= 3'd4) ? 2'd1 : 2'd2);
    lim = (f == 2'd0) ? 7'd23 : 7'd59;
    unique case (f)
      2'd0:    add = SecW'(p.acc) * SecW'(3600);
      2'd1:    add = SecW'(p.acc) * SecW'(60);
      default: add = SecW'(p.acc);
    endcase
    if ((p.neg && p.acc != 7'd0) || p.acc > lim) begin
      r = set_err(r, (part ? ST_STOP_HR : ST_START_HR) + 4'(f));
    end else begin
      if (part) r.stop_sec = p.stop_sec + add;
      else r.start_sec = p.start_sec + add;
      r.acc = '0;
      r.neg = 1'b0;
      if (term == CH_COLON && f < 2'd2) begin
        r.phase = {part, (f == 2'd0) ? 3'd2 : 3'd5};
      end else if (term == CH_MINUS && !part) begin
        r.phase = 4'd8;
      end else if (!(term == CH_END && part)) begin
        r = set_err(r, part ? ST_DANGLING : ST_NO_DASH);
      end
    end
    return r;
  endfunction

  function automatic parse_t feed(parse_t p, logic [7:0] c);
    parse_t r;
    logic [6:0] d;
    logic [10:0] v;
    r = p;
    d = 7'(c - CH_ZERO);
    v = 11'(p.acc) * 11'd10 + 11'(d);
    if (p.err == ST_OK) begin
      unique case (p.phase[2:0])
        3'd0: begin
          if (is_dig(c)) begin
            r.acc = d; r.neg = 1'b0; r.phase[0] = 1'b1;
          end else r = set_err(r, p.phase[3] ? ST_STOP_ND : ST_START_ND);
        end
        3'd1, 3'd4, 3'd7: begin
          if (is_dig(c)) r.acc = (v > 11'd127) ? 7'd127 : v[6:0];
          else r = close_field(p, c);
        end
        3'd2, 3'd5: begin
          r.acc = '0; r.neg = 1'b0;
          if (is_dig(c)) begin
            r.acc = d; r.phase = p.phase + 4'd2;
          end else if (c == CH_MINUS) r.phase = p.phase + 4'd1;
          else r = close_field(r, c);
        end
        default: begin
          if (is_dig(c)) begin
            r.acc = d; r.neg = 1'b1; r.phase = p.phase + 4'd1;
          end else begin
            r.acc = '0; r.neg = 1'b0;
            r = set_err(close_field(r, CH_MINUS), ST_STOP_ND);
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic parse_t finish(parse_t p);
    parse_t r;
    r = p;
    if (p.err == ST_OK) begin
      unique case (p.phase[2:0])
        3'd0: r = set_err(r, p.phase[3] ? ST_STOP_ND : ST_START_ND);
        3'd1, 3'd4, 3'd7: r = close_field(r, CH_END);
        3'd2, 3'd5: begin
          r.acc = '0; r.neg = 1'b0; r = close_field(r, CH_END);
        end
        default: begin
          r.acc = '0; r.neg = 1'b0;
          r = set_err(close_field(r, CH_MINUS), ST_STOP_ND);
        end
      endcase
    end
    return r;
  endfunction

  parse_t fed;
  always_comb begin
    if (cur_i.phase == 4'd0 && cur_i.err == ST_OK && !cur_i.illegal) fed = feed(cur_i, char_i);
    else if (char_i != CH_COLON && char_i != CH_MINUS && !is_dig(char_i)) begin
      fed = cur_i;
      fed.illegal = 1'b1;
    end else fed = feed(cur_i, char_i);
    nxt_o = last_i ? finish(fed) : fed;
  end
endmodule

// File: hw/rtl/twsm_checker.sv
`timescale 1ns / 1ps
module twsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] status_o,
  input logic       matched_o,
  input logic [4:0] window_count_o
);
  import twsm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(matched_o))
    else $error("stalled result changed");
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && matched_o |-> status_o == 4'd0) else $error("match with error");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_count_o <= 5'(MaxWindows)) else $error("count overflow");
endmodule

bind time_window_schedule_matcher twsm_checker u_twsm_checker (.*);
